[rtl/uwrg_pkg.sv]
// ----------------------------------------------------------------------------
// uwrg_pkg
// Shared types and constants of the uniform weight random generator.
// ----------------------------------------------------------------------------
package uwrg_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned BOUND_W = 24;
    localparam int unsigned WEIGHT_W = 25;
    localparam int unsigned FRAC_W  = 24;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned OUT_DATA_W = 96;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    typedef enum logic {
        CMD_RESEED = 1'b0,
        CMD_DRAW   = 1'b1
    } uwrg_op_t;

    typedef struct packed {
        uwrg_op_t          op;
        logic [WORD_W-1:0] seed;
    } uwrg_cmd_t;

    // Word writes and status from the seeding sequencer.
    typedef struct packed {
        logic              busy;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [WORD_W-1:0] wr_data;
    } uwrg_seed_wr_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
        rotl64 = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

[rtl/uwrg_front.sv]
// ----------------------------------------------------------------------------
// uwrg_front
// Input side: accepts stream items, tags them as reseed or draw commands and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module uwrg_front #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [63:0]             s_tdata,   // [63:0] seed_value
    input  logic [0:0]              s_tuser,   // [0] operation
    output logic                    head_valid,
    output uwrg_pkg::uwrg_cmd_t     head_cmd,
    input  logic                    head_pop
);
    import uwrg_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    uwrg_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    uwrg_cmd_t        in_cmd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign s_tready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        in_cmd.op   = s_tuser[0] ? CMD_DRAW : CMD_RESEED;
        in_cmd.seed = s_tdata;
    end

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = head_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !head_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && head_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/uwrg_seeder.sv]
// ----------------------------------------------------------------------------
// uwrg_seeder
// Splitmix64 sequencer: expands one seed into the four generator words using
// a single shared 32x32 multiplier for the 64-bit constant products.
// ----------------------------------------------------------------------------
module uwrg_seeder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [63:0]                 seed,
    output uwrg_pkg::uwrg_seed_wr_t     seed_wr
);
    import uwrg_pkg::*;

    typedef enum logic [4:0] {
        SEED_IDLE = 5'b00001,
        SEED_MUL0 = 5'b00010,
        SEED_MUL1 = 5'b00100,
        SEED_MUL2 = 5'b01000,
        SEED_MUL3 = 5'b10000
    } seed_state_t;

    seed_state_t       state_reg, state_next;
    logic              sel_b_reg, sel_b_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] mul_const;
    logic [31:0]       mul_a, mul_b;
    logic [WORD_W-1:0] start_z;
    logic [WORD_W-1:0] mul_result;
    logic [WORD_W-1:0] mixed;

    assign mul_const = sel_b_reg ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a = (state_reg == SEED_MUL1) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b = (state_reg == SEED_MUL2) ? mul_const[63:32] : mul_const[31:0];
    assign start_z = seed + GOLDEN_GAMMA;
    // The final partial product lands in the upper half only.
    assign mul_result = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
    assign mixed = mul_result ^ (mul_result >> 31);

    always_comb begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        idx_next   = idx_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        seed_wr.busy    = (state_reg != SEED_IDLE);
        seed_wr.wr_en   = 1'b0;
        seed_wr.wr_idx  = idx_reg;
        seed_wr.wr_data = mixed;
        case (state_reg)
            SEED_IDLE: begin
                if (start) begin
                    z_next     = start_z ^ (start_z >> 30);
                    sel_b_next = 1'b0;
                    idx_next   = '0;
                    state_next = SEED_MUL0;
                end
            end
            SEED_MUL0: begin
                state_next = SEED_MUL1;
            end
            SEED_MUL1: begin
                acc_next   = prod_reg;
                state_next = SEED_MUL2;
            end
            SEED_MUL2: begin
                acc_next   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                state_next = SEED_MUL3;
            end
            SEED_MUL3: begin
                if (!sel_b_reg) begin
                    z_next     = mul_result ^ (mul_result >> 27);
                    sel_b_next = 1'b1;
                    state_next = SEED_MUL0;
                end else begin
                    seed_wr.wr_en = 1'b1;
                    z_next     = mixed ^ (mixed >> 30);
                    sel_b_next = 1'b0;
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = (idx_reg == IDX_W'(NUM_WORDS - 1)) ? SEED_IDLE : SEED_MUL0;
                end
            end
            default: begin
                state_next = SEED_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_IDLE;
            sel_b_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_b_reg <= sel_b_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg    <= z_next;
        acc_reg  <= acc_next;
        prod_reg <= mul_a * mul_b;
    end

endmodule

[rtl/uwrg_back.sv]
// ----------------------------------------------------------------------------
// uwrg_back
// Back end: holds the four generator words, dispatches queued commands to the
// seeding sequencer or the draw path, and runs the output pipeline.
// ----------------------------------------------------------------------------
module uwrg_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    input  uwrg_pkg::uwrg_cmd_t     head_cmd,
    output logic                    head_pop,
    input  logic [23:0]             weight_bound,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [95:0]             m_tdata    // [63:0] raw_random, [88:64] weight_sample
);
    import uwrg_pkg::*;

    uwrg_seed_wr_t     seed_wr;
    logic              seed_start;
    logic              draw_issue;
    logic              seeded_reg;
    logic [WORD_W-1:0] word_reg [NUM_WORDS];

    logic [WORD_W-1:0] t_word, n0, n1, n2, n3;

    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic              p1_zero_reg, p2_zero_reg;
    logic [WORD_W-1:0] p1_mul5_reg;
    logic [WORD_W-1:0] p2_raw_reg;
    logic [WORD_W-1:0] p3_raw_reg;
    logic [WEIGHT_W-1:0] p3_weight_reg;
    logic              p1_ready, p2_ready, p3_ready;

    logic [WORD_W-1:0] p1_rot;
    logic signed [FRAC_W-1:0]  frac;
    logic signed [BOUND_W:0]   bound_s;
    logic signed [FRAC_W+BOUND_W:0] product;

    uwrg_seeder u_seeder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seed_start),
        .seed    (head_cmd.seed),
        .seed_wr (seed_wr)
    );

    // Elastic pipeline: a stage moves when its successor is empty or moving.
    assign p3_ready = !p3_valid_reg || m_tready;
    assign p2_ready = !p2_valid_reg || p3_ready;
    assign p1_ready = !p1_valid_reg || p2_ready;

    assign seed_start = head_valid && (head_cmd.op == CMD_RESEED) && !seed_wr.busy;
    assign draw_issue = head_valid && (head_cmd.op == CMD_DRAW) && !seed_wr.busy && p1_ready;
    assign head_pop   = seed_start || draw_issue;

    // xoshiro256 state advance.
    always_comb begin
        t_word = word_reg[1] << 17;
        n2 = word_reg[2] ^ word_reg[0];
        n3 = word_reg[3] ^ word_reg[1];
        n1 = word_reg[1] ^ n2;
        n0 = word_reg[0] ^ n3;
    end

    always_ff @(posedge aclk) begin
        if (seed_wr.wr_en) begin
            word_reg[seed_wr.wr_idx] <= seed_wr.wr_data;
        end else if (draw_issue && seeded_reg) begin
            word_reg[0] <= n0;
            word_reg[1] <= n1;
            word_reg[2] <= n2 ^ t_word;
            word_reg[3] <= rotl64(n3, 45);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= 1'b0;
        end else if (seed_wr.wr_en && (seed_wr.wr_idx == IDX_W'(NUM_WORDS - 1))) begin
            seeded_reg <= 1'b1;
        end
    end

    assign p1_rot  = rotl64(p1_mul5_reg, 7);
    // Top 24 bits less 2^23 is the top 24 bits with the sign bit flipped.
    assign frac    = {~p2_raw_reg[63], p2_raw_reg[62:40]};
    assign bound_s = {1'b0, weight_bound};
    assign product = frac * bound_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            if (p1_ready) begin
                p1_valid_reg <= draw_issue;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready && draw_issue) begin
            p1_zero_reg <= !seeded_reg;
            p1_mul5_reg <= word_reg[1] + (word_reg[1] << 2);
        end
        if (p2_ready && p1_valid_reg) begin
            p2_zero_reg <= p1_zero_reg;
            p2_raw_reg  <= p1_rot + (p1_rot << 3);
        end
        if (p3_ready && p2_valid_reg) begin
            // Dropping the low 23 product bits floors toward minus infinity.
            p3_raw_reg    <= p2_zero_reg ? '0 : p2_raw_reg;
            p3_weight_reg <= p2_zero_reg ? '0 : product[47:23];
        end
    end

    assign m_tvalid = p3_valid_reg;
    assign m_tdata  = {7'b0, p3_weight_reg, p3_raw_reg};

`ifndef NO_ASSERTIONS
    a_no_draw_while_seeding: assert property (@(posedge aclk) disable iff (!aresetn)
        draw_issue |-> !seed_wr.busy)
        else $error("draw issued while the seeding sequencer is busy");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> head_valid)
        else $error("queue popped while empty");

    a_seeded_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag cleared outside reset");

    a_single_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        !(seed_start && draw_issue))
        else $error("reseed and draw dispatched together");
`endif

endmodule

[rtl/uniform_weight_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// uniform_weight_random_generator_unit
// xoshiro256** generator with splitmix64 seeding and a scaled uniform weight.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser[0] selects the command (0 reseed, 1 draw) and
//   tdata carries the 64-bit seed for a reseed. A draw gives one transfer on
//   m_*: the raw 64-bit word and a signed Q2.22 weight in [-bound, bound).
//   A reseed gives no output transfer.
//   The cfg_* channel writes the unsigned Q2.22 weight bound; it is always
//   ready and must only be written while the block is idle.
// Throughput:
//   A draw passes from the command queue through the xor/rotate state update
//   and the three-stage output pipeline to m_tvalid; draws follow at one per
//   cycle while m_tready stays high and no reseed is running.
//   A reseed occupies the back end until all four splitmix64 mixes are done:
//   they share one 32x32 multiplier, each word passing SEED_MUL0 to SEED_MUL3
//   twice. Input transfers are still taken into the command queue meanwhile.
// Reset: the queue and pipeline empty, the bound returns to 1.0, and draws
//   return zeros until the first reseed completes.
// Stall: when m_tready is low the pipeline and queue fill, then s_tready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module uniform_weight_random_generator_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [63:0] raw_random, [88:64] weight_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data   // [23:0] weight_bound
);
    import uwrg_pkg::*;

    localparam logic [BOUND_W-1:0] BOUND_RESET = 24'h40_0000;

    logic [BOUND_W-1:0] bound_reg;
    logic               head_valid;
    uwrg_cmd_t          head_cmd;
    logic               head_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= BOUND_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bound_reg <= cfg_data;
        end
    end

    uwrg_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_pop   (head_pop)
    );

    uwrg_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .head_pop     (head_pop),
        .weight_bound (bound_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
